/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash-chain checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/lz77hc_pkg.sv */
// ----------------------------------------------------------------------------
// lz77hc_pkg
// Sizing constants, beat types, action codes and helpers of the hash-chain store.
// ----------------------------------------------------------------------------
package lz77hc_pkg;

  localparam int HASH_WIDTH    = 15;
  localparam int WINDOW_SIZE   = 32768;
  localparam int MIN_MATCH_LEN = 3;

  localparam int HASH_FIELD_W = 15;
  localparam int POS_W        = 16;
  localparam int BYTE_W       = 8;

  localparam int HASH_DEPTH  = 1 << HASH_WIDTH;
  localparam int WIN_BITS    = $clog2(WINDOW_SIZE);
  localparam int HASH_SHIFT  = (HASH_WIDTH + MIN_MATCH_LEN - 1) / MIN_MATCH_LEN;
  localparam int HCALC_W     = HASH_FIELD_W + HASH_SHIFT;
  localparam int SWEEP_BITS  = (HASH_WIDTH > WIN_BITS) ? HASH_WIDTH : WIN_BITS;
  localparam int SWEEP_DEPTH = 1 << SWEEP_BITS;
  localparam int CNT_W       = SWEEP_BITS + 1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_NEXT   = 2'd1,
    ACT_SLIDE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLIDE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [HASH_FIELD_W-1:0] hash_in;
    logic [BYTE_W-1:0]       byte_in;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [HASH_FIELD_W-1:0] hash_out;
    logic [POS_W-1:0]        chain_pos;
  } out_item_t;

  // Move a stored position down by one window; positions below it drop to zero.
  function automatic logic [POS_W-1:0] slid(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] win;
    win = POS_W'(WINDOW_SIZE);
    return (v >= win) ? (v - win) : '0;
  endfunction

endpackage

/* rtl/lz77hc_in_if.sv */
// ----------------------------------------------------------------------------
// lz77hc_in_if
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface lz77hc_in_if;
  import lz77hc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lz77hc_out_if.sv */
// ----------------------------------------------------------------------------
// lz77hc_out_if
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface lz77hc_out_if;
  import lz77hc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lz77_hash_chain_table_unit.sv */
// ----------------------------------------------------------------------------
// lz77_hash_chain_table_unit
// Head and prev tables of an LZ77 hash-chain match finder with insert,
// chain-follow and window-slide actions.
// ----------------------------------------------------------------------------
// Usage: each request beat produces exactly one result beat, in order. For insert,
// get-next and the unused action code the accept cycle issues the memory read
// (none for the unused code), the next cycle writes back (insert only) and loads
// the output register (it waits there while a previous result is still held on
// the output). Slide walks both tables together with one read-modify-write per
// entry, covering SWEEP_DEPTH entries, SWEEP_DEPTH being the larger table
// depth (32768 as configured), through the one read and one write port of
// each table. After reset a clearing pass writes zero to every entry, during
// which no request is taken. Only one request is in flight at a time.
// ----------------------------------------------------------------------------
module lz77_hash_chain_table_unit import lz77hc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  lz77hc_in_if.sink    in_chan,
  lz77hc_out_if.source out_chan
);

  localparam cnt_t SWEEP_END = cnt_t'(SWEEP_DEPTH);
  localparam cnt_t HASH_END  = cnt_t'(HASH_DEPTH);
  localparam cnt_t WIN_END   = cnt_t'(WINDOW_SIZE);
  localparam logic [HCALC_W-1:0] HMASK = HCALC_W'((1 << HASH_WIDTH) - 1);

  // Table storage: no reset, the clearing pass zeroes it.
  logic [POS_W-1:0] head_mem [0:HASH_DEPTH-1];
  logic [POS_W-1:0] prev_mem [0:WINDOW_SIZE-1];

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   pipe_vld_r, pipe_vld_nxt;
  cnt_t   pipe_addr_r, pipe_addr_nxt;

  // Request held for the write-back cycle.
  action_t                 act_r;
  logic [POS_W-1:0]        pos_r;
  logic [HASH_WIDTH-1:0]   hidx_r;
  logic [HASH_FIELD_W-1:0] hash_r;

  // Output register.
  logic                    out_valid_r;
  logic [HASH_FIELD_W-1:0] out_hash_r;
  logic [POS_W-1:0]        out_chain_r;

  // Memory ports.
  logic                  head_re, head_we, prev_re, prev_we;
  logic [HASH_WIDTH-1:0] head_ra, head_wa;
  logic [WIN_BITS-1:0]   prev_ra, prev_wa;
  logic [POS_W-1:0]      head_wd, prev_wd, head_q, prev_q;

  logic                    acc, out_free, out_load;
  action_t                 in_act;
  logic [HCALC_W-1:0]      h_full, h_masked;
  logic [HASH_WIDTH-1:0]   h_idx;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign acc           = in_chan.valid && in_chan.ready;
  assign in_act        = action_t'(in_chan.data.action);
  assign out_free      = !out_valid_r || out_chan.ready;

  // Roll the hash: shift in the new byte, keep HASH_WIDTH bits.
  assign h_full   = ({{HASH_SHIFT{1'b0}}, in_chan.data.hash_in} << HASH_SHIFT)
                    ^ HCALC_W'(in_chan.data.byte_in);
  assign h_masked = h_full & HMASK;
  assign h_idx    = h_full[HASH_WIDTH-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == SWEEP_END) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) state_nxt = (in_act == ACT_SLIDE) ? ST_SLIDE : ST_EXEC;
      end
      ST_SLIDE: begin
        if (cnt_r == SWEEP_END && !pipe_vld_r) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory control, sweep counter and output load.
  always_comb begin
    head_re       = 1'b0;
    head_ra       = '0;
    prev_re       = 1'b0;
    prev_ra       = '0;
    head_we       = 1'b0;
    head_wa       = '0;
    head_wd       = '0;
    prev_we       = 1'b0;
    prev_wa       = '0;
    prev_wd       = '0;
    cnt_nxt       = cnt_r;
    pipe_vld_nxt  = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // Zero one entry of each table per cycle.
        if (cnt_r != SWEEP_END) begin
          head_we = (cnt_r < HASH_END);
          head_wa = cnt_r[HASH_WIDTH-1:0];
          prev_we = (cnt_r < WIN_END);
          prev_wa = cnt_r[WIN_BITS-1:0];
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc) begin
          head_re = (in_act == ACT_INSERT);
          head_ra = h_idx;
          prev_re = (in_act == ACT_NEXT);
          prev_ra = in_chan.data.position[WIN_BITS-1:0];
        end
      end
      ST_SLIDE: begin
        // Read entry n while writing back entry n-1.
        if (cnt_r != SWEEP_END) begin
          head_re       = (cnt_r < HASH_END);
          head_ra       = cnt_r[HASH_WIDTH-1:0];
          prev_re       = (cnt_r < WIN_END);
          prev_ra       = cnt_r[WIN_BITS-1:0];
          pipe_vld_nxt  = 1'b1;
          pipe_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + cnt_t'(1);
        end
        if (pipe_vld_r) begin
          head_we = (pipe_addr_r < HASH_END);
          head_wa = pipe_addr_r[HASH_WIDTH-1:0];
          head_wd = slid(head_q);
          prev_we = (pipe_addr_r < WIN_END);
          prev_wa = pipe_addr_r[WIN_BITS-1:0];
          prev_wd = slid(prev_q);
        end
      end
      ST_EXEC: begin
        // Link the chain (insert only) and publish the result once the output has room.
        if (out_free) begin
          out_load = 1'b1;
          if (act_r == ACT_INSERT) begin
            head_we = 1'b1;
            head_wa = hidx_r;
            head_wd = pos_r;
            prev_we = 1'b1;
            prev_wa = pos_r[WIN_BITS-1:0];
            prev_wd = head_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Tables: one read and one write port each, registered read data.
  always_ff @(posedge clk) begin
    if (head_re) head_q <= head_mem[head_ra];
    if (head_we) head_mem[head_wa] <= head_wd;
  end

  always_ff @(posedge clk) begin
    if (prev_re) prev_q <= prev_mem[prev_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      if (out_load)            out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    pipe_addr_r <= pipe_addr_nxt;
    if (acc) begin
      act_r  <= in_act;
      pos_r  <= in_chan.data.position;
      hidx_r <= h_idx;
      hash_r <= (in_act == ACT_INSERT) ? h_masked[HASH_FIELD_W-1:0]
                                       : in_chan.data.hash_in;
    end
    if (out_load) begin
      out_hash_r <= hash_r;
      case (act_r)
        ACT_INSERT: out_chain_r <= head_q;
        ACT_NEXT:   out_chain_r <= prev_q;
        default:    out_chain_r <= '0;
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.data.hash_out  = out_hash_r;
  assign out_chan.data.chain_pos = out_chain_r;

endmodule

/* rtl/lz77hc_checker.sv */
// ----------------------------------------------------------------------------
// lz77hc_checker
// Port-level checks of the hash-chain store, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz77hc_checker import lz77hc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_acc, out_stall, acc_short, acc_none;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign acc_short = in_acc && (in_data.action != ACT_SLIDE);
  assign acc_none  = in_acc && (in_data.action == ACT_NONE);

  // Hold a stalled result beat.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

  // Drop ready right after a request beat: one request in flight.
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)

  // Deliver a short action through the execute state and the output register when the output has room.
  `ASSERT_NEXT(a_short_latency, clk, rst_n,
               $past(acc_short) && (!out_valid || out_ready), out_valid)

  // The unused action code echoes the hash and reports no chain position.
  `ASSERT_NEXT(a_none_result, clk, rst_n, $past(acc_none) && (!out_valid || out_ready),
               out_data.chain_pos == '0 && out_data.hash_out == $past(in_data.hash_in, 2))

endmodule

bind lz77_hash_chain_table_unit lz77hc_checker u_lz77hc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_data   (in_chan.data),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
